### hdl/bba_pkg.sv
// bba_pkg: shared types and constants of the block bitmap allocator
// item structs, operation and status codes, map geometry
// no dependencies
package bba_pkg;

    // map geometry
    localparam int MAP_BITS = 4096;
    localparam int WORD_W   = 64;
    localparam int BIT_W    = $clog2(WORD_W);
    localparam int MAP_WORDS = (MAP_BITS + WORD_W - 1) / WORD_W;
    localparam int WORD_AW  = $clog2(MAP_WORDS);

    // field widths
    localparam int FUNC_W   = 2;
    localparam int IDX_W    = 12;
    localparam int STAT_W   = 2;
    localparam int CFG_W    = 10;

    // bits-in-use limit must hold both the scaled byte count and MAP_BITS
    localparam int LIMIT_W  = ((CFG_W + 3) > ($clog2(MAP_BITS) + 1)) ?
                              (CFG_W + 3) : ($clog2(MAP_BITS) + 1);
    localparam int WCNT_W   = LIMIT_W - BIT_W + 1;

    localparam logic [CFG_W-1:0] CFG_RESET = CFG_W'(512);

    // operation codes
    localparam logic [FUNC_W-1:0] FUNC_ALLOC   = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_OCCUPY  = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_RELEASE = 2'd2;
    localparam logic [FUNC_W-1:0] FUNC_QUERY   = 2'd3;

    // status codes
    localparam logic [STAT_W-1:0] ST_DONE  = 2'd0;
    localparam logic [STAT_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STAT_W-1:0] ST_RANGE = 2'd2;

    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic [IDX_W-1:0]  block_index;
    } bba_in_t;

    typedef struct packed {
        logic [IDX_W-1:0]  result_index;
        logic [STAT_W-1:0] status;
        logic              was_free;
    } bba_out_t;

    // memory access request from the sequencer
    typedef struct packed {
        logic               wr_en;
        logic [WORD_AW-1:0] wr_addr;
        logic [WORD_W-1:0]  wr_data;
        logic               rd_en;
        logic [WORD_AW-1:0] rd_addr;
    } bba_mem_req_t;

endpackage

### hdl/bba_map_mem.sv
// bba_map_mem: usage map storage, one word per row, registered read
// per-row valid bits make never-written rows read as all free
// depends on bba_pkg
module bba_map_mem
    import bba_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  bba_mem_req_t       mem_req,
    output logic [WORD_W-1:0]  rd_data
);

    logic [WORD_W-1:0]    map_mem [MAP_WORDS];
    logic [MAP_WORDS-1:0] row_vld_reg;
    logic [WORD_W-1:0]    rd_word_reg;
    logic                 rd_vld_reg;

    // row storage
    always_ff @(posedge aclk) begin
        if (mem_req.wr_en) begin
            map_mem[mem_req.wr_addr] <= mem_req.wr_data;
        end
        if (mem_req.rd_en) begin
            rd_word_reg <= map_mem[mem_req.rd_addr];
        end
    end

    // valid bits, cleared at reset
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_vld_reg <= '0;
            rd_vld_reg  <= 1'b0;
        end else begin
            if (mem_req.wr_en) begin
                row_vld_reg[mem_req.wr_addr] <= 1'b1;
            end
            if (mem_req.rd_en) begin
                rd_vld_reg <= row_vld_reg[mem_req.rd_addr];
            end
        end
    end

    // unwritten row reads as free
    assign rd_data = rd_vld_reg ? rd_word_reg : '0;

endmodule

### hdl/bba_seq.sv
// bba_seq: operation sequencer, first-fit word scan and read-modify-write
// holds the pending result and the output register
// depends on bba_pkg
module bba_seq
    import bba_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  bba_in_t            s_data,
    output logic               m_valid,
    input  logic               m_ready,
    output bba_out_t           m_data,
    input  logic [LIMIT_W-1:0] limit,
    output bba_mem_req_t       mem_req,
    input  logic [WORD_W-1:0]  mem_rdata
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_SCAN = 3'd1;
    localparam logic [2:0] S_AWR  = 3'd2;
    localparam logic [2:0] S_RMW  = 3'd3;
    localparam logic [2:0] S_RES  = 3'd4;

    // lowest set bit of a nonzero word by halving
    function automatic logic [BIT_W-1:0] lowest_set(input logic [WORD_W-1:0] v);
        logic [WORD_W-1:0] tmp;
        logic [WORD_W-1:0] low_mask;
        logic [BIT_W-1:0]  pos;
        tmp = v;
        pos = '0;
        for (int lvl = BIT_W - 1; lvl >= 0; lvl--) begin
            low_mask = (WORD_W'(1) << (1 << lvl)) - WORD_W'(1);
            if ((tmp & low_mask) == '0) begin
                tmp = tmp >> (1 << lvl);
                pos[lvl] = 1'b1;
            end
        end
        return pos;
    endfunction

    logic [2:0]         state_reg, state_next;
    logic [FUNC_W-1:0]  func_reg, func_next;
    logic [IDX_W-1:0]   idx_reg, idx_next;
    logic [LIMIT_W-1:0] limit_reg, limit_next;
    logic [WCNT_W-1:0]  nwords_reg, nwords_next;
    logic [WCNT_W-1:0]  issue_reg, issue_next;
    logic [WORD_AW-1:0] chk_reg, chk_next;
    logic               chk_vld_reg, chk_vld_next;
    logic [WORD_AW-1:0] hit_addr_reg, hit_addr_next;
    logic [BIT_W-1:0]   hit_pos_reg, hit_pos_next;
    logic [WORD_W-1:0]  hit_word_reg, hit_word_next;
    bba_out_t           res_reg, res_next;
    logic               m_valid_reg, m_valid_next;
    bba_out_t           m_data_reg, m_data_next;

    logic [LIMIT_W-1:0] s_idx_ext;
    logic [WORD_W-1:0]  avail_mask;
    logic [WORD_W-1:0]  free_bits;
    logic [WCNT_W-1:0]  full_words;
    logic [WORD_W-1:0]  bit_mask;
    logic               cur_bit;

    assign s_ready   = (state_reg == S_IDLE);
    assign m_valid   = m_valid_reg;
    assign m_data    = m_data_reg;
    assign s_idx_ext = LIMIT_W'(s_data.block_index);

    // blocks of the checked word that lie below the limit
    assign full_words = WCNT_W'(limit_reg >> BIT_W);
    always_comb begin
        if (WCNT_W'(chk_reg) < full_words) begin
            avail_mask = '1;
        end else if (WCNT_W'(chk_reg) == full_words) begin
            avail_mask = (WORD_W'(1) << limit_reg[BIT_W-1:0]) - WORD_W'(1);
        end else begin
            avail_mask = '0;
        end
    end
    assign free_bits = ~mem_rdata & avail_mask;

    // addressed bit for occupy, release, query
    assign bit_mask = WORD_W'(1) << idx_reg[BIT_W-1:0];
    assign cur_bit  = mem_rdata[idx_reg[BIT_W-1:0]];

    // next-state logic
    always_comb begin
        state_next    = state_reg;
        func_next     = func_reg;
        idx_next      = idx_reg;
        limit_next    = limit_reg;
        nwords_next   = nwords_reg;
        issue_next    = issue_reg;
        chk_next      = chk_reg;
        chk_vld_next  = 1'b0;
        hit_addr_next = hit_addr_reg;
        hit_pos_next  = hit_pos_reg;
        hit_word_next = hit_word_reg;
        res_next      = res_reg;
        m_valid_next  = m_valid_reg && !m_ready;
        m_data_next   = m_data_reg;
        mem_req       = '0;

        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    func_next   = s_data.func;
                    idx_next    = s_data.block_index;
                    limit_next  = limit;
                    nwords_next = WCNT_W'((LIMIT_W + 1)'(limit) +
                                          (LIMIT_W + 1)'(WORD_W - 1) >> BIT_W);
                    issue_next  = '0;
                    if (s_data.func == FUNC_ALLOC) begin
                        if (limit == '0) begin
                            res_next   = '{result_index: '0, status: ST_FULL,
                                           was_free: 1'b0};
                            state_next = S_RES;
                        end else begin
                            state_next = S_SCAN;
                        end
                    end else if (s_idx_ext >= limit) begin
                        res_next   = '{result_index: s_data.block_index,
                                       status: ST_RANGE, was_free: 1'b0};
                        state_next = S_RES;
                    end else begin
                        mem_req.rd_en   = 1'b1;
                        mem_req.rd_addr = WORD_AW'(s_data.block_index >> BIT_W);
                        state_next      = S_RMW;
                    end
                end
            end

            // one read issued per cycle, the previous word checked
            S_SCAN: begin
                if (issue_reg < nwords_reg) begin
                    mem_req.rd_en   = 1'b1;
                    mem_req.rd_addr = issue_reg[WORD_AW-1:0];
                    issue_next      = issue_reg + WCNT_W'(1);
                    chk_next        = issue_reg[WORD_AW-1:0];
                    chk_vld_next    = 1'b1;
                end
                if (chk_vld_reg) begin
                    if (free_bits != '0) begin
                        hit_addr_next = chk_reg;
                        hit_pos_next  = lowest_set(free_bits);
                        hit_word_next = mem_rdata;
                        chk_vld_next  = 1'b0;
                        state_next    = S_AWR;
                    end else if (WCNT_W'(chk_reg) == nwords_reg - WCNT_W'(1)) begin
                        res_next     = '{result_index: '0, status: ST_FULL,
                                         was_free: 1'b0};
                        chk_vld_next = 1'b0;
                        state_next   = S_RES;
                    end
                end
            end

            // mark the found block used
            S_AWR: begin
                mem_req.wr_en   = 1'b1;
                mem_req.wr_addr = hit_addr_reg;
                mem_req.wr_data = hit_word_reg | (WORD_W'(1) << hit_pos_reg);
                res_next        = '{result_index: IDX_W'({hit_addr_reg, hit_pos_reg}),
                                    status: ST_DONE, was_free: 1'b1};
                state_next      = S_RES;
            end

            // word read back, bit updated for occupy and release
            S_RMW: begin
                mem_req.wr_addr = WORD_AW'(idx_reg >> BIT_W);
                if (func_reg == FUNC_OCCUPY) begin
                    mem_req.wr_en   = 1'b1;
                    mem_req.wr_data = mem_rdata | bit_mask;
                end else if (func_reg == FUNC_RELEASE) begin
                    mem_req.wr_en   = 1'b1;
                    mem_req.wr_data = mem_rdata & ~bit_mask;
                end
                res_next   = '{result_index: idx_reg, status: ST_DONE,
                               was_free: !cur_bit};
                state_next = S_RES;
            end

            // hand the result to the output register once it is free
            S_RES: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    m_data_next  = res_reg;
                    state_next   = S_IDLE;
                end
            end

            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            chk_vld_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            chk_vld_reg <= chk_vld_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        func_reg     <= func_next;
        idx_reg      <= idx_next;
        limit_reg    <= limit_next;
        nwords_reg   <= nwords_next;
        issue_reg    <= issue_next;
        chk_reg      <= chk_next;
        hit_addr_reg <= hit_addr_next;
        hit_pos_reg  <= hit_pos_next;
        hit_word_reg <= hit_word_next;
        res_reg      <= res_next;
        m_data_reg   <= m_data_next;
    end

endmodule

### hdl/block_bitmap_allocator.sv
// block_bitmap_allocator: first-fit allocator over a 4096-block usage map.
// Occupy, release, query: addressed word read, rewritten for occupy and release.
// Allocate: one map word scanned per cycle from the memory's single read port,
// result at the first word with a free block; one item in work at a time.
// Reset (aresetn low, synchronous) frees every block at once through per-row
// valid bits, with no clearing pass, and sets bytes_reg to 512.
module block_bitmap_allocator
    import bba_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  bba_in_t          s_data,
    output logic             m_valid,
    input  logic             m_ready,
    output bba_out_t         m_data,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [CFG_W-1:0] cfg_data
);

    logic [CFG_W-1:0]   bytes_reg;
    logic [CFG_W-1:0]   bytes_next;
    logic [LIMIT_W-1:0] bits_scaled;
    logic [LIMIT_W-1:0] limit;
    bba_mem_req_t       mem_req;
    logic [WORD_W-1:0]  mem_rdata;

    assign cfg_ready = 1'b1;

    // map length register
    assign bytes_next = cfg_valid ? cfg_data : bytes_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bytes_reg <= CFG_RESET;
        end else begin
            bytes_reg <= bytes_next;
        end
    end

    // bits in use, capped at the map size
    assign bits_scaled = LIMIT_W'(bytes_reg) << 3;
    assign limit = (bits_scaled > LIMIT_W'(MAP_BITS)) ? LIMIT_W'(MAP_BITS) : bits_scaled;

    bba_seq u_seq (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .limit     (limit),
        .mem_req   (mem_req),
        .mem_rdata (mem_rdata)
    );

    bba_map_mem u_map (
        .aclk    (aclk),
        .aresetn (aresetn),
        .mem_req (mem_req),
        .rd_data (mem_rdata)
    );

endmodule

### hdl/bba_checker.sv
// bba_checker: port-level checks of the block bitmap allocator
// bound to block_bitmap_allocator; depends on bba_pkg
module bba_checker
    import bba_pkg::*;
(
    input logic             aclk,
    input logic             aresetn,
    input logic             s_valid,
    input logic             s_ready,
    input logic             m_valid,
    input logic             m_ready,
    input bba_out_t         m_data
);

    // one item in flight: busy right after an accept
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input accepted while an item is still in work");

    // a full map reports no index and no free block
    a_full_result: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_data.status == ST_FULL) |->
            (m_data.result_index == '0) && !m_data.was_free)
        else $error("full status with nonzero index or was_free");

    // out-of-range items never report a free block, status stays in its codes
    a_status_codes: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> ((m_data.status == ST_DONE) || (m_data.status == ST_FULL) ||
                     ((m_data.status == ST_RANGE) && !m_data.was_free)))
        else $error("bad status or was_free on range error");

    // stalled result holds
    a_result_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result changed or dropped while stalled");

endmodule

bind block_bitmap_allocator bba_checker u_bba_checker (.*);
